FILE: rtl/core/mfm_pkg.sv
`default_nettype none
package mfm_pkg;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_SYNC  = 2'd1,
    OP_INDEX = 2'd2,
    OP_CRC   = 2'd3
  } op_t;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_RESET  = 16'hFFFF;
  localparam logic [15:0] SYNC_WORD  = 16'h4489;
  localparam logic [15:0] INDEX_WORD = 16'h5224;
  localparam logic [7:0]  SYNC_BYTE  = 8'hA1;

  // Register index of the CRC preset on the configuration port.
  localparam logic REG_CRC_PRESET = 1'b0;

  // One classified command as it waits in the queue (the word count travels apart).
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [15:0] word;
    logic        prev;
  } mfm_enc_t;

  // CRC-CCITT, MSB first, one byte folded in.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // MFM cells for one byte: a clock bit is set only between two zero data bits.
  function automatic mfm_enc_t mfm_byte(input logic [7:0] b, input logic prev_in);
    mfm_enc_t r;
    logic     p;
    p = prev_in;
    for (int i = 7; i >= 0; i--) begin
      r.word[2*i+1] = ~b[i] & ~p;
      r.word[2*i]   = b[i];
      p             = b[i];
    end
    r.prev = p;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mfm_in_if.sv
`default_nettype none
interface mfm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic [6:0] repeat_count;

  modport source (output valid, output op, output data_byte, output repeat_count,
                  input ready);
  modport sink (input valid, input op, input data_byte, input repeat_count,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mfm_out_if.sv
`default_nettype none
interface mfm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mfm_word;
  logic        last_of_run;

  modport source (output valid, output mfm_word, output last_of_run, input ready);
  modport sink (input valid, input mfm_word, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mfm_front.sv
`default_nettype none
module mfm_front
  import mfm_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 64,
  localparam int unsigned CNT_W = $clog2(((MAX_REPEAT > 2) ? MAX_REPEAT : 2) + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  mfm_in_if.sink                in_ch,
  output logic                  head_valid,
  output cmd_t                  head_cmd,
  output logic [CNT_W-1:0]      head_n,
  input  wire logic             head_pop
);

  localparam int unsigned QDEPTH = 2;

  cmd_t             q_cmd_r [QDEPTH];
  logic [CNT_W-1:0] q_n_r   [QDEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             push;
  op_t              in_op;
  logic [CNT_W-1:0] n_sat;

  assign in_op       = op_t'(in_ch.op);
  assign in_ch.ready = (fill_r != 2'(QDEPTH));
  assign push        = in_ch.valid & in_ch.ready;

  // Word count of the command: two for a CRC, else the repeat clamped to 1..MAX_REPEAT.
  always_comb begin
    priority if (in_op == OP_CRC) begin
      n_sat = CNT_W'(2);
    end else if (in_ch.repeat_count == '0) begin
      n_sat = CNT_W'(1);
    end else if (32'(in_ch.repeat_count) > MAX_REPEAT) begin
      n_sat = CNT_W'(MAX_REPEAT);
    end else begin
      n_sat = CNT_W'(in_ch.repeat_count);
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = head_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd_r[wr_ptr_r] <= '{op: in_op, data_byte: in_ch.data_byte};
      q_n_r[wr_ptr_r]   <= n_sat;
    end
  end

  assign head_valid = (fill_r != '0);
  assign head_cmd   = q_cmd_r[rd_ptr_r];
  assign head_n     = q_n_r[rd_ptr_r];

endmodule
`default_nettype wire

FILE: rtl/core/mfm_back.sv
`default_nettype none
module mfm_back
  import mfm_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 64,
  localparam int unsigned CNT_W = $clog2(((MAX_REPEAT > 2) ? MAX_REPEAT : 2) + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [15:0]      crc_preset,
  input  wire logic             head_valid,
  input  wire cmd_t             head_cmd,
  input  wire logic [CNT_W-1:0] head_n,
  output logic                  head_pop,
  mfm_out_if.source             out_ch
);

  logic             prev_r, prev_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             sync_r, sync_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_word_r, word;
  logic             out_last_r, last;
  logic             advance;
  mfm_enc_t         enc;
  logic [7:0]       enc_byte;

  assign advance  = head_valid & (~out_valid_r | out_ch.ready);
  assign last     = ((cnt_r + CNT_W'(1)) == head_n);
  assign head_pop = advance & last;

  // The CRC command sends the high byte first, then the low one.
  assign enc_byte = (head_cmd.op == OP_CRC) ? ((cnt_r == '0) ? crc_r[15:8] : crc_r[7:0])
                                            : head_cmd.data_byte;
  assign enc      = mfm_byte(enc_byte, prev_r);

  always_comb begin
    prev_nxt = prev_r;
    crc_nxt  = crc_r;
    sync_nxt = sync_r;
    word     = enc.word;
    unique case (head_cmd.op)
      OP_DATA: begin
        prev_nxt = enc.prev;
        crc_nxt  = crc_fold(crc_r, head_cmd.data_byte);
        sync_nxt = 1'b0;
      end
      OP_SYNC: begin
        prev_nxt = 1'b1;
        crc_nxt  = crc_fold(sync_r ? crc_r : crc_preset, SYNC_BYTE);
        sync_nxt = 1'b1;
        word     = SYNC_WORD;
      end
      OP_INDEX: begin
        prev_nxt = 1'b0;
        sync_nxt = 1'b0;
        word     = INDEX_WORD;
      end
      OP_CRC: begin
        prev_nxt = enc.prev;
        sync_nxt = 1'b0;
      end
      default: begin
        prev_nxt = prev_r;
      end
    endcase
    cnt_nxt       = last ? '0 : cnt_r + CNT_W'(1);
    out_valid_nxt = advance | (out_valid_r & ~out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= 1'b0;
      crc_r       <= CRC_RESET;
      sync_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        prev_r <= prev_nxt;
        crc_r  <= crc_nxt;
        sync_r <= sync_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= word;
      out_last_r <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mfm_word    = out_word_r;
  assign out_ch.last_of_run = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/core/mfm_floppy_write_encoder.sv
// Path: an accepted command is written into the queue; its words are then loaded from
// the queue head into the output register, which drives the output channel.
// Throughput: one MFM word per cycle while the receiver holds ready high; a command
// has 1..MAX_REPEAT words, two for a CRC, all through the single-word output register.
// Reset (rst_n, synchronous, active low) empties the queue and output, clears the
// previous data bit and sync-run flag, and sets the CRC and its preset to 0xFFFF.
`default_nettype none
module mfm_floppy_write_encoder
  import mfm_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mfm_in_if.sink           in_ch,
  mfm_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned CNT_W = $clog2(((MAX_REPEAT > 2) ? MAX_REPEAT : 2) + 1);

  // Configuration: a single register, the CRC preset, at byte address 0. The word
  // index is address bit 2; a write to any other index is dropped.
  logic [15:0] crc_preset_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_preset_r <= CRC_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_CRC_PRESET)) begin
      crc_preset_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CRC_PRESET) ? {16'h0000, crc_preset_r} : '0;

  // The front takes one transaction per cycle while its queue has room, clamps its
  // repeat count and queues it. The back walks the queue head word by word, encoding,
  // folding the CRC and loading the output register, and pops the head with its last word.
  logic             head_valid;
  cmd_t             head_cmd;
  logic [CNT_W-1:0] head_n;
  logic             head_pop;

  mfm_front #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_n     (head_n),
    .head_pop   (head_pop)
  );

  mfm_back #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .crc_preset (crc_preset_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_n     (head_n),
    .head_pop   (head_pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

FILE: test/mfm_word_scoreboard_pkg.sv
package mfm_word_scoreboard_pkg;
  import mfm_pkg::*;

  localparam int unsigned REPEAT_LIMIT = 64;

  typedef struct packed {
    logic [15:0] mfm_word;
    logic        last_of_run;
  } mfm_result_t;

  // Tracks the encoder state on the accepted command stream and holds the MFM words
  // that are still owed by the block.
  class mfm_word_scoreboard;
    mfm_result_t expected_words[$];
    logic [15:0] crc_preset;
    logic [15:0] crc_value;
    logic        prev_data;
    logic        sync_run;
    int unsigned errors;

    function new();
      crc_preset = CRC_RESET;
      crc_value  = CRC_RESET;
      prev_data  = 1'b0;
      sync_run   = 1'b0;
      errors     = 0;
    endfunction

    function void write_register(int unsigned index, logic [31:0] value);
      if (index == int'(REG_CRC_PRESET)) begin
        crc_preset = value[15:0];
      end
    endfunction

    // Bit-serial CRC-CCITT update, MSB of the byte first.
    function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function logic [15:0] encode(logic [7:0] b);
      logic [15:0] w;
      w = '0;
      for (int i = 7; i >= 0; i--) begin
        w         = {w[13:0], ~b[i] & ~prev_data, b[i]};
        prev_data = b[i];
      end
      return w;
    endfunction

    function void owe(logic [15:0] w, logic last);
      mfm_result_t r;
      r.mfm_word    = w;
      r.last_of_run = last;
      expected_words.push_back(r);
    endfunction

    function void note_command(op_t op, logic [7:0] b, logic [6:0] rep);
      int unsigned n;
      logic [15:0] w;
      n = (rep == 0) ? 1 : ((rep > REPEAT_LIMIT) ? REPEAT_LIMIT : rep);
      if (op == OP_CRC) begin
        // The CRC bytes go out but are not folded back into the CRC.
        sync_run = 1'b0;
        owe(encode(crc_value[15:8]), 1'b0);
        owe(encode(crc_value[7:0]), 1'b1);
        return;
      end
      for (int unsigned k = 0; k < n; k++) begin
        case (op)
          OP_DATA: begin
            w         = encode(b);
            crc_value = crc_byte(crc_value, b);
            sync_run  = 1'b0;
          end
          OP_SYNC: begin
            if (!sync_run) begin
              crc_value = crc_preset;
            end
            crc_value = crc_byte(crc_value, SYNC_BYTE);
            sync_run  = 1'b1;
            prev_data = 1'b1;
            w         = SYNC_WORD;
          end
          default: begin
            sync_run  = 1'b0;
            prev_data = 1'b0;
            w         = INDEX_WORD;
          end
        endcase
        owe(w, k == n - 1);
      end
    endfunction

    function void check_word(logic [15:0] w, logic last, realtime stamp);
      mfm_result_t exp;
      if (expected_words.size() == 0) begin
        $display("%0t ns: word %h last %b arrived with nothing expected", stamp, w, last);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      if (exp.mfm_word !== w) begin
        $display("%0t ns: mfm_word expected %h actual %h", stamp, exp.mfm_word, w);
        errors++;
      end
      if (exp.last_of_run !== last) begin
        $display("%0t ns: last_of_run expected %b actual %b", stamp, exp.last_of_run, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

FILE: test/tb_mfm_floppy_write_encoder.sv
module tb_mfm_floppy_write_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mfm_pkg::*;
  import mfm_word_scoreboard_pkg::*;

  // Register indexes on the configuration port. Only the preset exists; the spare
  // index is written to show that the block ignores it.
  localparam int unsigned REG_PRESET_IDX = int'(REG_CRC_PRESET);
  localparam int unsigned REG_SPARE_IDX  = 1;

  // Bytes that make up a typical IBM track.
  localparam logic [7:0] GAP_BYTE  = 8'h4E;
  localparam logic [7:0] IDAM_BYTE = 8'hFE;
  localparam logic [7:0] DAM_BYTE  = 8'hFB;
  localparam logic [7:0] DDAM_BYTE = 8'hF8;

  localparam realtime RUN_LIMIT = 5ms;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_COIN,
    RX_EVERY_THIRD,
    RX_SPARSE
  } rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mfm_in_if  in_if ();
  mfm_out_if out_if ();

  mfm_floppy_write_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if.sink),
    .out_ch     (out_if.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  mfm_word_scoreboard sb = new();

  // Number of commands the block has taken so far.
  int items_sent = 0;
  // Commands left in the current sender burst before a gap may be inserted.
  int burst_left = 0;
  // Set by the stimulus thread to ask the receiver for one long hold-off; the receiver
  // takes the request over and counts the cycles down itself.
  int hold_request = 0;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // Safety net: a correct run finishes well inside this time.
  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver. It cycles through a few back-pressure styles, each held for a random
  // stretch, so stalls land on every word of long repeat runs as well as on CRC pairs.
  // A pending hold-off request overrides the style and keeps ready low for the whole
  // requested stretch while the sender keeps pushing commands.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       rx_tick;
    mode      = RX_FLOW;
    mode_left = 0;
    hold_left = 0;
    rx_tick   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          RX_FLOW:        out_if.ready <= 1'b1;
          RX_COIN:        out_if.ready <= 1'($urandom_range(0, 1));
          RX_EVERY_THIRD: out_if.ready <= (rx_tick % 3 != 0);
          default:        out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Every word transaction on the output goes straight to the scoreboard. Sampling
  // happens at the rising edge, before the block's registers update.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_word(out_if.mfm_word, out_if.last_of_run, $realtime);
    end
  end

  // Drops valid for a number of cycles to open a gap in the command stream.
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
  endtask

  // Offers one command and waits for its transaction. The fields are changed on the
  // falling edge; the transaction is recognized on the rising edge. Bursts of random
  // length are followed by random gaps, and some bursts run straight into the next.
  task automatic offer(input op_t op, input logic [7:0] b, input logic [6:0] rep);
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.op           <= op;
    in_if.data_byte    <= b;
    in_if.repeat_count <= rep;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    sb.note_command(op, b, rep);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 5));
      end
    end
  endtask

  // Stops offering and waits until every owed word has come out, plus a short margin,
  // so that the block is idle before the next register write.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the data at the edge
  // where the access cycle completes.
  task automatic write_register(input int unsigned index, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(index * 4);
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    sb.write_register(index, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Repeat counts lean toward short runs, with the full range, zero and values past
  // the saturation point showing up now and then.
  function automatic logic [6:0] pick_repeat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 7'($urandom_range(1, 4));
    end else if (r < 85) begin
      return 7'($urandom_range(5, 16));
    end else if (r < 95) begin
      return 7'($urandom_range(17, 64));
    end else if (r < 99) begin
      return 7'($urandom_range(65, 127));
    end else begin
      return 7'd0;
    end
  endfunction

  // One address or data field the way a formatter writes it: gap, zero run, sync marks
  // (three in most fields), the address mark, the payload and the CRC. Now and then an
  // index mark leads, the sync marks are split over several commands, or the CRC is
  // missing to leave a broken field behind.
  task automatic send_frame();
    logic [7:0] mark;
    int         n;
    if ($urandom_range(0, 4) == 0) begin
      offer(OP_INDEX, 8'($urandom), 7'($urandom_range(1, 3)));
    end
    offer(OP_DATA, GAP_BYTE, 7'($urandom_range(1, 24)));
    offer(OP_DATA, 8'h00, 7'($urandom_range(1, 12)));
    case ($urandom_range(0, 3))
      0: begin
        repeat (3) offer(OP_SYNC, 8'($urandom), 7'd1);
      end
      1: offer(OP_SYNC, 8'($urandom), 7'($urandom_range(1, 4)));
      default: offer(OP_SYNC, 8'($urandom), 7'd3);
    endcase
    case ($urandom_range(0, 3))
      0: mark = IDAM_BYTE;
      1: mark = DDAM_BYTE;
      2: mark = 8'($urandom);
      default: mark = DAM_BYTE;
    endcase
    offer(OP_DATA, mark, 7'd1);
    n = $urandom_range(1, 8);
    repeat (n) begin
      offer(OP_DATA, 8'($urandom), ($urandom_range(0, 4) == 0) ? pick_repeat() : 7'd1);
    end
    if ($urandom_range(0, 9) != 0) begin
      offer(OP_CRC, 8'($urandom), 7'($urandom));
    end
  endtask

  // A few commands of any kind with any content.
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      offer(op_t'($urandom_range(0, 3)), 8'($urandom), pick_repeat());
    end
  endtask

  task automatic random_phase(input int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        send_frame();
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_if.valid        = 1'b0;
    in_if.op           = OP_DATA;
    in_if.data_byte    = '0;
    in_if.repeat_count = 7'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Writes to the spare index must leave the preset alone; the preset is then
    // written back to its reset value with garbage in the unused upper bits.
    write_register(REG_SPARE_IDX, 32'h0000_1234);
    write_register(REG_PRESET_IDX, 32'hA5A5_FFFF);

    // Directed part: all-zero and all-one bytes, zero and saturating repeat counts,
    // sync runs that span several commands, an index mark breaking a sync run,
    // CRC commands whose repeat count is ignored, and the clock bit that follows a
    // mark of either kind.
    offer(OP_DATA, 8'h00, 7'd1);
    offer(OP_DATA, 8'hFF, 7'd1);
    offer(OP_DATA, 8'h00, 7'd0);
    offer(OP_DATA, GAP_BYTE, 7'd64);
    offer(OP_DATA, 8'h55, 7'd65);
    offer(OP_DATA, 8'hAA, 7'd127);
    offer(OP_SYNC, 8'h00, 7'd3);
    offer(OP_SYNC, 8'hFF, 7'd1);
    offer(OP_DATA, IDAM_BYTE, 7'd1);
    offer(OP_DATA, 8'h12, 7'd2);
    offer(OP_CRC, 8'h00, 7'd0);
    offer(OP_CRC, 8'hFF, 7'd127);
    offer(OP_INDEX, 8'hFF, 7'd1);
    offer(OP_SYNC, 8'h00, 7'd1);
    offer(OP_INDEX, 8'h00, 7'd0);
    offer(OP_DATA, 8'h00, 7'd1);
    offer(OP_SYNC, 8'h00, 7'd64);
    offer(OP_DATA, 8'h01, 7'd1);
    offer(OP_INDEX, 8'hA1, 7'd127);
    offer(OP_CRC, 8'h5A, 7'd1);
    offer(OP_SYNC, 8'hFF, 7'd2);
    offer(OP_DATA, 8'h80, 7'd1);
    offer(OP_CRC, 8'h00, 7'd64);
    drain();

    // First random phase runs with an arbitrary preset.
    write_register(REG_PRESET_IDX, $urandom);
    random_phase(95);
    drain();

    // Second phase: zero preset, and the receiver holds off long enough for the
    // block to back up and refuse commands.
    write_register(REG_PRESET_IDX, {16'($urandom), 16'h0000});
    hold_request = 400;
    random_phase(165);
    drain();

    // Last phase returns to the all-ones preset after a write to the spare index.
    write_register(REG_SPARE_IDX, 32'h0000_0000);
    write_register(REG_PRESET_IDX, 32'h0000_FFFF);
    random_phase(235);
    drain();

    // Quiet tail so that any stray word after the last expected one is caught.
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: mfm_floppy_write_encoder.f
rtl/core/mfm_pkg.sv
rtl/core/mfm_in_if.sv
rtl/core/mfm_out_if.sv
rtl/core/mfm_front.sv
rtl/core/mfm_back.sv
rtl/core/mfm_floppy_write_encoder.sv
test/mfm_word_scoreboard_pkg.sv
test/tb_mfm_floppy_write_encoder.sv
